// ----- design/tws_pkg.sv -----
// Shared constants and types for the timestamp window sorter.
package tws_pkg;

    localparam int DEPTH       = 256;
    localparam int TIME_BITS   = 48;
    localparam int HANDLE_BITS = 16;
    localparam int COUNT_BITS  = $clog2(DEPTH + 1);

    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [HANDLE_BITS-1:0] t_handle;
    typedef logic [COUNT_BITS-1:0]  t_count;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_POP    = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_WORK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
    } t_cmd;

endpackage

// ----- design/tws_if.sv -----
// Handshake channels of the timestamp window sorter.
interface tws_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    tws_pkg::t_time       hit_time;
    tws_pkg::t_handle     hit_handle;

    modport source (output valid, output action, output hit_time, output hit_handle,
                    input ready);
    modport sink   (input valid, input action, input hit_time, input hit_handle,
                    output ready);
endinterface

interface tws_out_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    tws_pkg::t_time       out_time;
    tws_pkg::t_handle     out_handle;
    logic                 have_hit;
    tws_pkg::t_count      held_count;

    modport source (output valid, output status, output out_time, output out_handle,
                    output have_hit, output held_count, input ready);
    modport sink   (input valid, input status, input out_time, input out_handle,
                    input have_hit, input held_count, output ready);
endinterface

interface tws_cfg_if;
    logic                 valid;
    logic                 ready;
    tws_pkg::t_time       window;

    modport source (output valid, output window, input ready);
    modport sink   (input valid, input window, output ready);
endinterface

// ----- design/timestamp_window_sorter_unit.sv -----
// Timestamp window sorter: one item in flight, results through an output register.
// The result is registered: a pending register holds it until the output register is free.
// A new item is not taken until its result is loaded. Steps: the parallel compare-and-shift
// over the cell row on accept, then the span compare and the load of the output register.
// Reset empties the store and clears the window to zero; cell contents are not cleared.
module timestamp_window_sorter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tws_in_if.sink      i_hit,
    tws_out_if.source   o_res,
    tws_cfg_if.sink     i_cfg
);

    tws_pkg::t_cmd cmd;
    logic          in_ready;
    logic          out_valid;
    logic          cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    tws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_hit.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd)
    );

    assign i_hit.ready = in_ready;
    assign o_res.valid = out_valid;

    tws_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_hit.action),
        .i_hit_time   (i_hit.hit_time),
        .i_hit_handle (i_hit.hit_handle),
        .i_cfg_we     (cfg_we),
        .i_cfg_window (i_cfg.window),
        .o_status     (o_res.status),
        .o_out_time   (o_res.out_time),
        .o_out_handle (o_res.out_handle),
        .o_have_hit   (o_res.have_hit),
        .o_held_count (o_res.held_count)
    );

endmodule

// ----- design/tws_ctrl.sv -----
// Controller: sequences accept, status and output handoff of one item at a time.
module tws_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tws_pkg::t_cmd o_cmd
);

    tws_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tws_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        unique case (r_state)
            tws_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = tws_pkg::S_WORK;
            end
            tws_pkg::S_WORK: begin
                // hold the result until the output register frees up
                o_cmd.load = !r_out_valid || i_out_ready;
                if (o_cmd.load) n_state = tws_pkg::S_IDLE;
            end
            default: n_state = tws_pkg::S_IDLE;
        endcase

        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- design/tws_dp.sv -----
// Datapath: row of sorted cells with parallel compare and shift, plus result registers.
module tws_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tws_pkg::t_cmd    i_cmd,
    input  logic             i_action,
    input  tws_pkg::t_time   i_hit_time,
    input  tws_pkg::t_handle i_hit_handle,
    input  logic             i_cfg_we,
    input  tws_pkg::t_time   i_cfg_window,
    output logic [1:0]       o_status,
    output tws_pkg::t_time   o_out_time,
    output tws_pkg::t_handle o_out_handle,
    output logic             o_have_hit,
    output tws_pkg::t_count  o_held_count
);

    localparam tws_pkg::t_count FULL_COUNT = tws_pkg::COUNT_BITS'(tws_pkg::DEPTH);
    localparam tws_pkg::t_count TWO_COUNT  = tws_pkg::COUNT_BITS'(2);

    tws_pkg::t_time   r_time   [tws_pkg::DEPTH];
    tws_pkg::t_handle r_handle [tws_pkg::DEPTH];
    tws_pkg::t_count  r_count;
    tws_pkg::t_time   r_newest;
    tws_pkg::t_time   r_window;

    // pending result of the accepted item
    tws_pkg::t_status r_pend_status;
    tws_pkg::t_time   r_pend_time;
    tws_pkg::t_handle r_pend_handle;

    // output register
    tws_pkg::t_status r_o_status;
    tws_pkg::t_time   r_o_time;
    tws_pkg::t_handle r_o_handle;
    logic             r_o_have_hit;
    tws_pkg::t_count  r_o_count;

    logic [tws_pkg::DEPTH-1:0] gt;
    logic [tws_pkg::DEPTH-1:0] take_prev;
    logic [tws_pkg::DEPTH-1:0] take_new;
    logic                      is_full;
    logic                      is_empty;
    logic                      do_insert;
    logic                      do_pop;
    tws_pkg::t_time            span;

    assign is_full   = (r_count == FULL_COUNT);
    assign is_empty  = (r_count == '0);
    assign do_insert = i_cmd.accept && (i_action == tws_pkg::ACT_INSERT) && !is_full;
    assign do_pop    = i_cmd.accept && (i_action == tws_pkg::ACT_POP) && !is_empty;

    // Each held cell flags a timestamp above the new one; the flags are monotone,
    // so the first flagged cell (or the fill point) takes the new hit.
    always_comb begin
        for (int k = 0; k < tws_pkg::DEPTH; k++) begin
            gt[k] = (tws_pkg::COUNT_BITS'(k) < r_count) && (r_time[k] > i_hit_time);
        end
        take_prev[0] = 1'b0;
        for (int k = 1; k < tws_pkg::DEPTH; k++) begin
            take_prev[k] = gt[k-1];
        end
        for (int k = 0; k < tws_pkg::DEPTH; k++) begin
            take_new[k] = !take_prev[k] && (gt[k] || (tws_pkg::COUNT_BITS'(k) == r_count));
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            if (take_new[0]) begin
                r_time[0]   <= i_hit_time;
                r_handle[0] <= i_hit_handle;
            end
            for (int k = 1; k < tws_pkg::DEPTH; k++) begin
                if (take_prev[k]) begin
                    r_time[k]   <= r_time[k-1];
                    r_handle[k] <= r_handle[k-1];
                end else if (take_new[k]) begin
                    r_time[k]   <= i_hit_time;
                    r_handle[k] <= i_hit_handle;
                end
            end
        end else if (do_pop) begin
            // advance every cell one place toward the head
            for (int k = 0; k < tws_pkg::DEPTH - 1; k++) begin
                r_time[k]   <= r_time[k+1];
                r_handle[k] <= r_handle[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_window <= '0;
        end else begin
            if (i_cfg_we) r_window <= i_cfg_window;
            if (do_insert) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Newest timestamp tracks the tail cell; equal times land behind it.
    always_ff @(posedge i_clk) begin
        if (do_insert && (is_empty || (i_hit_time >= r_newest))) begin
            r_newest <= i_hit_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (i_action == tws_pkg::ACT_INSERT) begin
                r_pend_status <= is_full ? tws_pkg::ST_FULL : tws_pkg::ST_OK;
                r_pend_time   <= '0;
                r_pend_handle <= '0;
            end else if (is_empty) begin
                r_pend_status <= tws_pkg::ST_EMPTY;
                r_pend_time   <= '0;
                r_pend_handle <= '0;
            end else begin
                r_pend_status <= tws_pkg::ST_OK;
                r_pend_time   <= r_time[0];
                r_pend_handle <= r_handle[0];
            end
        end
    end

    assign span = r_newest - r_time[0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status   <= r_pend_status;
            r_o_time     <= r_pend_time;
            r_o_handle   <= r_pend_handle;
            r_o_have_hit <= (r_count >= TWO_COUNT) && (span > r_window);
            r_o_count    <= r_count;
        end
    end

    assign o_status     = r_o_status;
    assign o_out_time   = r_o_time;
    assign o_out_handle = r_o_handle;
    assign o_have_hit   = r_o_have_hit;
    assign o_held_count = r_o_count;

endmodule
